// ----- hw/rtl/qwsp_pkg.sv -----
package qwsp_pkg;

  localparam int NUM_WHEELS = 4;
  localparam int DRIVE_MAX  = 180;
  localparam int WA_W       = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;

  // feedforward 0.0535*s^2 + 17.8*s + 92.9 in Q16.16, s in Q8.8
  localparam int FF_A     = 3506;
  localparam int FF_B     = 4557;
  localparam int FF_C     = 6088294;
  // 8 eighths * 1000 ms * 256 (Q8.8)
  localparam int SPEED_K  = 2048000;
  localparam int MS_PER_S = 1000;

  // ceil(2^38 / 1000): exact quotient by 1000 for any 32-bit operand
  localparam int RECIP_1000 = 274877907;
  localparam int RECIP_SH   = 38;

  localparam int DIV_MW = 58;          // numerator magnitude bits
  localparam int DIV_NW = DIV_MW + 1;  // signed numerator
  localparam int DEN_W  = 26;          // ticks_per_meter_eighths * elapsed_ms
  localparam int TOT_W  = 60;          // Q16.16 drive accumulator

  localparam int IN_W  = 32;
  localparam int OUT_W = 64;
  localparam int CFG_W = 16;
  localparam int IDX_W = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_TPM,
    REG_INVERT
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL1,
    ST_DIVS,
    ST_SPEED,
    ST_MUL2,
    ST_MUL3,
    ST_IRA,
    ST_IRB,
    ST_IRC,
    ST_IADD,
    ST_DIVD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [31:0] error_sum;
    logic signed [23:0] last_error;
    logic [1:0]         pin_history;
    logic [31:0]        ticks_at_last;
    logic [31:0]        ticks;
  } wheel_state_t;

  // quadrature transition: index is {old B, old A, new B, new A}
  function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
    logic signed [1:0] s;
    unique case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: s = 2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: s = -2'sd1;
      default: s = 2'sd0;
    endcase
    return s;
  endfunction

endpackage

// ----- hw/rtl/qwsp_ram.sv -----
module qwsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/qwsp_div.sv -----
module qwsp_div (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [qwsp_pkg::DIV_NW-1:0]    num,
  input  logic [qwsp_pkg::DEN_W-1:0]            den,
  output logic                                  done,
  output logic signed [qwsp_pkg::DIV_NW-1:0]    quo
);
  import qwsp_pkg::*;

  localparam int CNT_W = $clog2(DIV_MW + 1);

  logic [DIV_MW-1:0] acc;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  dvs;
  logic              neg;
  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DIV_NW-1:0] mag;
  logic [DEN_W:0]    shifted;
  logic [DEN_W:0]    trial;

  assign mag     = num[DIV_NW-1] ? DIV_NW'(-num) : DIV_NW'(num);
  assign shifted = {rem, acc[DIV_MW-1]};
  assign trial   = shifted - {1'b0, dvs};
  assign quo     = neg ? -$signed({1'b0, acc}) : $signed({1'b0, acc});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_MW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // restoring division on magnitudes, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= mag[DIV_MW-1:0];
      rem <= '0;
      dvs <= den;
      neg <= num[DIV_NW-1];
    end else if (busy) begin
      acc <= {acc[DIV_MW-2:0], ~trial[DEN_W]};
      rem <= trial[DEN_W] ? shifted[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

endmodule

// ----- hw/rtl/quadrature_wheel_speed_pid.sv -----
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tuser: op; tdata: wheel, pin_ab, target_speed, elapsed_ms
// m_*      out  m_tvalid/m_tready  tdata: out_wheel, drive_value, measured_speed, tick_count
// cfg_*    in   cfg_we             cfg_index selects register, cfg_data
//
// One request at a time. An encoder sample is accepted with a state read, then written back.
// A control tick makes two passes through the shared bit-serial divider (speed, derivative term);
// the integral term divides by 1000 by reciprocal multiplication in steps.
// Reset is synchronous; per-wheel state reads as zero until first written.
// A new request is taken while a result waits on m_*; a tick then holds in its last step.
module quadrature_wheel_speed_pid (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [qwsp_pkg::IN_W-1:0]     s_tdata,   // wheel, pin_ab, target_speed, elapsed_ms
  input  logic                          s_tuser,   // op
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [qwsp_pkg::OUT_W-1:0]    m_tdata,   // out_wheel, drive_value, measured_speed,
                                                   // tick_count
  input  logic                          cfg_we,
  input  logic [qwsp_pkg::IDX_W-1:0]    cfg_index,
  input  logic [qwsp_pkg::CFG_W-1:0]    cfg_data
);
  import qwsp_pkg::*;

  state_t state, state_next;
  logic   launch, launch_next;

  logic [15:0] gain_p, gain_i, gain_d, tpm8;
  logic [3:0]  invert_mask;

  logic              op;
  logic [1:0]        wheel;
  logic [1:0]        pins;
  logic signed [11:0] target;
  logic [9:0]        ms;
  logic              in_range;

  logic [NUM_WHEELS-1:0] vld;
  logic                  rd_vld;
  logic                  ram_we;
  wheel_state_t          ram_wdata, ram_rdata, cur, st;

  logic                  div_done;
  logic signed [DIV_NW-1:0] div_num, div_quo;
  logic [DEN_W-1:0]      div_den;

  logic [15:0]              tpm_eff;
  logic signed [31:0]       delta;
  logic signed [31:0]       stp;
  logic signed [53:0]       spd_prod;
  logic [DEN_W-1:0]         den_prod, den_r;
  logic signed [DIV_NW-1:0] n_spd, n_d;
  logic signed [15:0]       speed, spd_sat;
  logic signed [16:0]       err, err_c;
  logic signed [24:0]       derr, derr_c;
  logic signed [32:0]       sum33;
  logic signed [31:0]       sum, sum_c;
  logic signed [33:0]       p, p_c;
  logic signed [41:0]       y, y_c;
  logic signed [23:0]       tt, tt_c;
  logic signed [25:0]       fb, fb_c;
  logic signed [52:0]       nd_c;
  logic signed [36:0]       ffa, ffa_c;
  logic signed [TOT_W-1:0]  acc, acc_init, acc_hi;
  logic [7:0]               drive;

  // integral term: |sum| * gain_i * ms / 1000 split into 32-bit reciprocal steps
  logic [25:0]              i_scale, i_scale_c;
  logic [31:0]              smag;
  logic                     sneg;
  logic [31:0]              rec_in;
  logic [60:0]              rec_prod;
  logic [22:0]              rec_q;
  logic [22:0]              sa;
  logic [9:0]               sb, cb;
  logic [15:0]              ca;
  logic [32:0]              sa_k, sb_full;
  logic [25:0]              ca_k, cb_full;
  logic [48:0]              t1;
  logic [25:0]              t2;
  logic [19:0]              t3;
  logic [49:0]              imag;
  logic signed [50:0]       i_term;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p      <= 16'd2560;
      gain_i      <= 16'd26;
      gain_d      <= 16'd51;
      tpm8        <= 16'd11811;
      invert_mask <= 4'd12;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_GAIN_P: gain_p      <= cfg_data;
        REG_GAIN_I: gain_i      <= cfg_data;
        REG_GAIN_D: gain_d      <= cfg_data;
        REG_TPM:    tpm8        <= cfg_data;
        REG_INVERT: invert_mask <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  qwsp_ram #(
    .WIDTH($bits(wheel_state_t)),
    .DEPTH(NUM_WHEELS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(WA_W'(wheel)),
    .wdata(ram_wdata),
    .raddr(WA_W'(s_tdata[1:0])),
    .rdata(ram_rdata)
  );

  qwsp_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(launch),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  assign cur      = rd_vld ? ram_rdata : '0;
  assign in_range = int'(wheel) < NUM_WHEELS;
  assign tpm_eff  = (tpm8 == 16'd0) ? 16'd1 : tpm8;

  // encoder step
  logic signed [1:0] step_raw;
  assign step_raw = quad_step({cur.pin_history, pins});
  assign stp      = invert_mask[wheel] ? -step_raw : step_raw;

  // arithmetic
  assign spd_prod = delta * $signed(22'(SPEED_K));
  assign den_prod = tpm_eff * ms;
  assign spd_sat  = (div_quo > $signed(DIV_NW'(32767)))  ? 16'sh7FFF :
                    (div_quo < $signed(-DIV_NW'(32768))) ? 16'sh8000 : div_quo[15:0];
  assign err_c    = target - speed;
  assign derr_c   = err_c - st.last_error;
  assign sum33    = st.error_sum + err_c;
  assign sum_c    = (sum33 > 33'sh07FFFFFFF) ? 32'sh7FFFFFFF :
                    (sum33 < -33'sh080000000) ? 32'sh80000000 : sum33[31:0];
  assign p_c      = $signed({1'b0, gain_p}) * err;
  assign y_c      = $signed({1'b0, gain_d}) * derr;
  assign tt_c     = target * target;
  assign fb_c     = target * $signed(14'(FF_B));
  assign nd_c     = y * $signed(11'(MS_PER_S));
  assign ffa_c    = tt * $signed(13'(FF_A));
  assign acc_init = p + fb + $signed(TOT_W'(FF_C));
  assign acc_hi   = acc >>> 16;

  assign i_scale_c = gain_i * ms;
  assign rec_prod  = rec_in * $unsigned(29'(RECIP_1000));
  assign rec_q     = rec_prod[60:RECIP_SH];
  assign sa_k      = sa * 10'(MS_PER_S);
  assign sb_full   = {1'b0, smag} - sa_k;
  assign ca_k      = ca * 10'(MS_PER_S);
  assign cb_full   = i_scale - ca_k;
  assign cb        = cb_full[9:0];
  assign i_term    = sneg ? -$signed({1'b0, imag}) : $signed({1'b0, imag});

  always_comb begin
    unique case (state)
      ST_IRA:  rec_in = {6'd0, i_scale};
      ST_IRC:  rec_in = {12'd0, t3};
      default: rec_in = smag;
    endcase
  end

  always_comb begin
    if (acc[TOT_W-1]) begin
      drive = 8'd0;
    end else if (acc_hi > $signed(TOT_W'(DRIVE_MAX))) begin
      drive = 8'(DRIVE_MAX);
    end else begin
      drive = acc_hi[7:0];
    end
  end

  always_comb begin
    unique case (state)
      ST_DIVD: begin
        div_num = n_d;
        div_den = DEN_W'(ms);
      end
      default: begin
        div_num = n_spd;
        div_den = den_r;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      launch <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= launch_next;
    end
  end

  always_comb begin
    state_next  = state;
    launch_next = 1'b0;
    s_tready    = 1'b0;
    ram_we      = 1'b0;
    ram_wdata   = st;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (!in_range) begin
          state_next = ST_IDLE;
        end else if (!op) begin
          ram_we                = 1'b1;
          ram_wdata             = cur;
          ram_wdata.ticks       = cur.ticks + stp;
          ram_wdata.pin_history = pins;
          state_next            = ST_IDLE;
        end else begin
          state_next = ST_MUL1;
        end
      end
      ST_MUL1: begin
        state_next  = ST_DIVS;
        launch_next = 1'b1;
      end
      ST_DIVS: if (div_done) state_next = ST_SPEED;
      ST_SPEED: state_next = ST_MUL2;
      ST_MUL2:  state_next = ST_MUL3;
      ST_MUL3:  state_next = ST_IRA;
      ST_IRA:   state_next = ST_IRB;
      ST_IRB:   state_next = ST_IRC;
      ST_IRC:   state_next = ST_IADD;
      ST_IADD: begin
        state_next  = ST_DIVD;
        launch_next = 1'b1;
      end
      ST_DIVD: if (div_done) state_next = ST_DONE;
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          ram_we                  = 1'b1;
          ram_wdata.ticks_at_last = st.ticks;
          ram_wdata.last_error    = 24'(err);
          ram_wdata.error_sum     = sum;
          state_next              = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // valid bits for the state store
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ram_we) begin
      vld[WA_W'(wheel)] <= 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op     <= s_tuser;
      wheel  <= s_tdata[1:0];
      pins   <= s_tdata[3:2];
      target <= s_tdata[15:4];
      ms     <= (s_tdata[25:16] == 10'd0) ? 10'd1 : s_tdata[25:16];
      rd_vld <= vld[WA_W'(s_tdata[1:0])];
    end
    unique case (state)
      ST_LOAD: begin
        st    <= cur;
        delta <= cur.ticks - cur.ticks_at_last;
      end
      ST_MUL1: begin
        n_spd <= DIV_NW'(spd_prod);
        den_r <= den_prod;
      end
      ST_DIVS: if (div_done) speed <= spd_sat;
      ST_SPEED: begin
        err  <= err_c;
        derr <= derr_c;
        sum  <= sum_c;
      end
      ST_MUL2: begin
        p       <= p_c;
        y       <= y_c;
        tt      <= tt_c;
        fb      <= fb_c;
        i_scale <= i_scale_c;
        smag    <= sum[31] ? $unsigned(-sum) : $unsigned(sum);
        sneg    <= sum[31];
      end
      ST_MUL3: begin
        n_d <= DIV_NW'(nd_c);
        ffa <= ffa_c;
        acc <= acc_init;
        sa  <= rec_q;
      end
      ST_IRA: begin
        ca <= rec_q[15:0];
        sb <= sb_full[9:0];
      end
      // |sum| * scale / 1000 = scale*sa + ca*sb + cb*sb/1000
      ST_IRB: begin
        t1 <= i_scale * sa;
        t2 <= ca * sb;
        t3 <= cb * sb;
      end
      ST_IRC: imag <= 50'(t1) + 50'(t2) + 50'(rec_q);
      ST_IADD: acc <= acc + TOT_W'(i_term) + (ffa >>> 16);
      ST_DIVD: if (div_done) acc <= acc + div_quo;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {6'd0, st.ticks, speed, drive, wheel};
    end
  end

`ifndef SYNTHESIS
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIVS || state == ST_DIVD))
    else $error("divider finished outside a divide step");
  a_ram_we: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_LOAD || state == ST_DONE))
    else $error("state store written outside load or done");
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_DONE))
    else $error("result raised without a finished control tick");
  a_drive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[9:2] <= 8'(DRIVE_MAX)))
    else $error("drive value above limit");
`endif

endmodule
